// File: rtl/imhq_pkg.sv
package imhq_pkg;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_FULL  = 2'd1;
   localparam logic [1:0] ERR_EMPTY = 2'd2;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DELETE = 1'b1;

   // datapath command, one per cycle
   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_INS_START,
      OP_DEL_START,
      OP_DEL_LOAD,
      OP_DEL_LAST,
      OP_UP_RD,
      OP_UP_SWAP,
      OP_UP_MOVE,
      OP_DN_RDL,
      OP_DN_RDR,
      OP_DN_SWAP,
      OP_DN_MOVE,
      OP_WRITE_MOV,
      OP_DR_RD,
      OP_DR_LOAD
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] err;
      logic       load_plain;
   } dp_cmd_type;

   typedef struct packed {
      logic cmd;
      logic empty;
      logic full;
      logic one;
      logic at_root;
      logic up_before;
      logic dn_has_left;
      logic dn_swap;
      logic out_free;
      logic drain_last;
   } dp_status_type;

endpackage

// File: rtl/imhq_ram.sv
module imhq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one word, read one word registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/imhq_ctrl.sv
module imhq_ctrl
   import imhq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    dp_cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_PLAIN,
      ST_DEL_WAIT,
      ST_UP_READ,
      ST_UP_CMP,
      ST_UP_PUSH2,
      ST_DN_RDL,
      ST_DN_RDR,
      ST_DN_CMP,
      ST_DN_PUSH2,
      ST_FIN,
      ST_DR_RD,
      ST_DR_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] err_ff, err_in;

   // pick next state and the datapath command
   always_comb begin
      state_in       = state_ff;
      err_in         = err_ff;
      dp_cmd.op      = OP_NOP;
      dp_cmd.err     = err_ff;
      dp_cmd.load_plain = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dp_cmd.op = OP_ACCEPT;
               state_in  = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            priority if (status.cmd == CMD_INSERT && status.full) begin
               err_in   = ERR_FULL;
               state_in = ST_PLAIN;
            end else if (status.cmd == CMD_DELETE && status.empty) begin
               err_in   = ERR_EMPTY;
               state_in = ST_PLAIN;
            end else if (status.cmd == CMD_DELETE && status.one) begin
               dp_cmd.op = OP_DEL_LAST;
               err_in    = ERR_NONE;
               state_in  = ST_PLAIN;
            end else if (status.cmd == CMD_INSERT) begin
               dp_cmd.op = OP_INS_START;
               state_in  = ST_UP_READ;
            end else begin
               dp_cmd.op = OP_DEL_START;
               state_in  = ST_DEL_WAIT;
            end
         end
         ST_PLAIN: begin
            if (status.out_free) begin
               dp_cmd.load_plain = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         ST_DEL_WAIT: begin
            dp_cmd.op = OP_DEL_LOAD;
            state_in  = ST_DN_RDL;
         end
         ST_UP_READ: begin
            if (status.at_root) begin
               state_in = ST_FIN;
            end else begin
               dp_cmd.op = OP_UP_RD;
               state_in  = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (status.up_before) begin
               dp_cmd.op = OP_UP_SWAP;
               state_in  = ST_UP_PUSH2;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_UP_PUSH2: begin
            dp_cmd.op = OP_UP_MOVE;
            state_in  = ST_UP_READ;
         end
         ST_DN_RDL: begin
            if (status.dn_has_left) begin
               dp_cmd.op = OP_DN_RDL;
               state_in  = ST_DN_RDR;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_DN_RDR: begin
            dp_cmd.op = OP_DN_RDR;
            state_in  = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            if (status.dn_swap) begin
               dp_cmd.op = OP_DN_SWAP;
               state_in  = ST_DN_PUSH2;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_DN_PUSH2: begin
            dp_cmd.op = OP_DN_MOVE;
            state_in  = ST_DN_RDL;
         end
         ST_FIN: begin
            dp_cmd.op = OP_WRITE_MOV;
            state_in  = ST_DR_RD;
         end
         ST_DR_RD: begin
            dp_cmd.op = OP_DR_RD;
            state_in  = ST_DR_OUT;
         end
         ST_DR_OUT: begin
            if (status.out_free) begin
               dp_cmd.op = OP_DR_LOAD;
               state_in  = status.drain_last ? ST_IDLE : ST_DR_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         err_ff   <= ERR_NONE;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

// File: rtl/imhq_dp.sv
module imhq_dp
   import imhq_pkg::*;
#(
   parameter int HEAP_DEPTH = 1024,
   parameter int ID_BITS    = 16,
   parameter int COST_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dp_cmd_type                    dp_cmd,
   output dp_status_type                 status,
   input  logic                          csr_we,
   input  logic                          csr_data,
   input  logic                          req_cmd,
   input  logic [ID_BITS-1:0]            req_node_id,
   input  logic [COST_BITS-1:0]          req_f_cost,
   input  logic [COST_BITS-1:0]          req_h_cost,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_is_update,
   output logic [ID_BITS-1:0]            rsp_moved_id,
   output logic [$clog2(HEAP_DEPTH)-1:0] rsp_slot,
   output logic [ID_BITS-1:0]            rsp_head_id,
   output logic                          rsp_head_valid,
   output logic [1:0]                    rsp_error_code,
   output logic                          rsp_last
);

   localparam int SW  = $clog2(HEAP_DEPTH);
   localparam int CW  = $clog2(HEAP_DEPTH + 1);
   localparam int EW  = ID_BITS + 2 * COST_BITS;
   localparam int RBN = 1 + 2 * SW;
   localparam int RBA = $clog2(RBN);
   localparam int RBW = $clog2(RBN + 1);
   localparam int QW  = ID_BITS + SW;

   // entry layout: id, f, h from high to low
   function automatic logic [ID_BITS-1:0] id_of(input logic [EW-1:0] e);
      id_of = e[EW-1 -: ID_BITS];
   endfunction

   function automatic logic ranks_before(input logic [EW-1:0] a,
                                         input logic [EW-1:0] b,
                                         input logic          m);
      logic [COST_BITS-1:0] af, ah, bf, bh;
      af = a[2*COST_BITS-1 -: COST_BITS];
      ah = a[COST_BITS-1:0];
      bf = b[2*COST_BITS-1 -: COST_BITS];
      bh = b[COST_BITS-1:0];
      if (m) begin
         ranks_before = ah < bh;
      end else begin
         ranks_before = (af < bf) || (af == bf && ah < bh);
      end
   endfunction

   logic              mode_ff;
   logic              cmd_ff;
   logic [CW-1:0]     cnt_ff;
   logic [SW-1:0]     cell_ff;
   logic [SW-1:0]     bsel_ff;
   logic [EW-1:0]     mov_ff;
   logic [EW-1:0]     lft_ff;
   logic [ID_BITS-1:0] head_ff;
   logic [RBW-1:0]    nres_ff;
   logic [RBW-1:0]    rptr_ff;

   logic              hp_we, hp_re;
   logic [SW-1:0]     hp_waddr, hp_raddr;
   logic [EW-1:0]     hp_wdata, hp_rdata;
   logic              rb_we, rb_re;
   logic [QW-1:0]     rb_wdata, rb_rdata;

   logic [SW-1:0]     par;
   logic [SW+1:0]     lchild, rchild, cnt_x;
   logic              l_before, r_better;
   logic [EW-1:0]     best_ent;
   logic [SW-1:0]     best_slot;
   logic              out_load;

   logic              out_valid_ff, out_upd_ff, out_hv_ff, out_last_ff;
   logic [ID_BITS-1:0] out_mid_ff, out_hid_ff;
   logic [SW-1:0]     out_slot_ff;
   logic [1:0]        out_err_ff;

   // neighbor slots and the three-way pick for sifting down
   assign par      = (cell_ff - SW'(1)) >> 1;
   assign lchild   = {1'b0, cell_ff, 1'b1};
   assign rchild   = lchild + (SW+2)'(1);
   assign cnt_x    = (SW+2)'(cnt_ff);
   assign l_before = ranks_before(lft_ff, mov_ff, mode_ff);
   assign best_ent = l_before ? lft_ff : mov_ff;
   assign r_better = (rchild < cnt_x) && ranks_before(hp_rdata, best_ent, mode_ff);
   assign best_slot = r_better ? rchild[SW-1:0] : lchild[SW-1:0];

   // status toward the controller
   assign out_load           = (dp_cmd.op == OP_DR_LOAD) || dp_cmd.load_plain;
   assign status.cmd         = cmd_ff;
   assign status.empty       = (cnt_ff == '0);
   assign status.full        = (cnt_ff == CW'(HEAP_DEPTH));
   assign status.one         = (cnt_ff == CW'(1));
   assign status.at_root     = (cell_ff == '0);
   assign status.up_before   = ranks_before(mov_ff, hp_rdata, mode_ff);
   assign status.dn_has_left = (lchild < cnt_x);
   assign status.dn_swap     = l_before || r_better;
   assign status.out_free    = !out_valid_ff || rsp_ready;
   assign status.drain_last  = ((rptr_ff + RBW'(1)) == nres_ff);

   // heap memory port control
   always_comb begin
      hp_we    = 1'b0;
      hp_waddr = cell_ff;
      hp_wdata = mov_ff;
      hp_re    = 1'b0;
      hp_raddr = par;
      rb_we    = 1'b0;
      rb_wdata = {id_of(mov_ff), cell_ff};
      rb_re    = 1'b0;
      unique case (dp_cmd.op)
         OP_INS_START: begin
            rb_we    = 1'b1;
            rb_wdata = {id_of(mov_ff), cnt_ff[SW-1:0]};
         end
         OP_DEL_START: begin
            hp_re    = 1'b1;
            hp_raddr = SW'(cnt_ff - CW'(1));
         end
         OP_DEL_LOAD: begin
            rb_we    = 1'b1;
            rb_wdata = {id_of(hp_rdata), {SW{1'b0}}};
         end
         OP_UP_RD: begin
            hp_re = 1'b1;
         end
         OP_UP_SWAP: begin
            hp_we    = 1'b1;
            hp_wdata = hp_rdata;
            rb_we    = 1'b1;
            rb_wdata = {id_of(hp_rdata), cell_ff};
         end
         OP_UP_MOVE: begin
            rb_we    = 1'b1;
            rb_wdata = {id_of(mov_ff), par};
         end
         OP_DN_RDL: begin
            hp_re    = 1'b1;
            hp_raddr = lchild[SW-1:0];
         end
         OP_DN_RDR: begin
            hp_re    = 1'b1;
            hp_raddr = rchild[SW-1:0];
         end
         OP_DN_SWAP: begin
            hp_we    = 1'b1;
            hp_wdata = r_better ? hp_rdata : lft_ff;
            rb_we    = 1'b1;
            rb_wdata = {id_of(hp_wdata), cell_ff};
         end
         OP_DN_MOVE: begin
            rb_we    = 1'b1;
            rb_wdata = {id_of(mov_ff), bsel_ff};
         end
         OP_WRITE_MOV: begin
            hp_we = 1'b1;
         end
         OP_DR_RD: begin
            rb_re = 1'b1;
         end
         default: ;
      endcase
   end

   imhq_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_heap (
      .clock   (clock),
      .wr_en   (hp_we),
      .wr_addr (hp_waddr),
      .wr_data (hp_wdata),
      .rd_en   (hp_re),
      .rd_addr (hp_raddr),
      .rd_data (hp_rdata)
   );

   imhq_ram #(.WIDTH(QW), .DEPTH(RBN)) u_rbuf (
      .clock   (clock),
      .wr_en   (rb_we),
      .wr_addr (nres_ff[RBA-1:0]),
      .wr_data (rb_wdata),
      .rd_en   (rb_re),
      .rd_addr (rptr_ff[RBA-1:0]),
      .rd_data (rb_rdata)
   );

   // control registers: mode, count, valid flag of the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            mode_ff <= csr_data;
         end
         unique case (dp_cmd.op)
            OP_INS_START: cnt_ff <= cnt_ff + CW'(1);
            OP_DEL_START: cnt_ff <= cnt_ff - CW'(1);
            OP_DEL_LAST:  cnt_ff <= '0;
            default: ;
         endcase
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // working registers of the sift
   always_ff @(posedge clock) begin
      if (hp_we && hp_waddr == '0) begin
         head_ff <= id_of(hp_wdata);
      end
      if (rb_we) begin
         nres_ff <= nres_ff + RBW'(1);
      end
      unique case (dp_cmd.op)
         OP_ACCEPT: begin
            cmd_ff  <= req_cmd;
            mov_ff  <= {req_node_id, req_f_cost, req_h_cost};
            nres_ff <= '0;
            rptr_ff <= '0;
         end
         OP_INS_START: cell_ff <= cnt_ff[SW-1:0];
         OP_DEL_START: cell_ff <= '0;
         OP_DEL_LOAD:  mov_ff  <= hp_rdata;
         OP_UP_MOVE:   cell_ff <= par;
         OP_DN_RDR:    lft_ff  <= hp_rdata;
         OP_DN_SWAP:   bsel_ff <= best_slot;
         OP_DN_MOVE:   cell_ff <= bsel_ff;
         OP_DR_LOAD:   rptr_ff <= rptr_ff + RBW'(1);
         default: ;
      endcase
   end

   // load the result beat
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_hv_ff  <= !status.empty;
         out_hid_ff <= status.empty ? '0 : head_ff;
         out_last_ff <= dp_cmd.load_plain || status.drain_last;
         if (dp_cmd.load_plain) begin
            out_upd_ff  <= 1'b0;
            out_mid_ff  <= '0;
            out_slot_ff <= '0;
            out_err_ff  <= dp_cmd.err;
         end else begin
            out_upd_ff  <= 1'b1;
            out_mid_ff  <= rb_rdata[QW-1 -: ID_BITS];
            out_slot_ff <= rb_rdata[SW-1:0];
            out_err_ff  <= ERR_NONE;
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_is_update  = out_upd_ff;
   assign rsp_moved_id   = out_mid_ff;
   assign rsp_slot       = out_slot_ff;
   assign rsp_head_id    = out_hid_ff;
   assign rsp_head_valid = out_hv_ff;
   assign rsp_error_code = out_err_ff;
   assign rsp_last       = out_last_ff;

endmodule

// File: rtl/indexed_min_heap_queue_top.sv
// Operation: an item is accepted and checked, then sifted up a level per loop on insert
// or down a level per loop on delete; its moves are then drained from a result buffer as beats.
// Items: one at a time; a new request is taken only after the last result beat
// of the previous item has been loaded into the output register.
// Reset: synchronous, active high; empties the heap and clears the mode
// register. Memory contents are not cleared and need no clearing pass.
module indexed_min_heap_queue_top
   import imhq_pkg::*;
#(
   parameter int HEAP_DEPTH = 1024,
   parameter int ID_BITS    = 16,
   parameter int COST_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic [ID_BITS-1:0]            req_node_id,
   input  logic [COST_BITS-1:0]          req_f_cost,
   input  logic [COST_BITS-1:0]          req_h_cost,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_is_update,
   output logic [ID_BITS-1:0]            rsp_moved_id,
   output logic [$clog2(HEAP_DEPTH)-1:0] rsp_slot,
   output logic [ID_BITS-1:0]            rsp_head_id,
   output logic                          rsp_head_valid,
   output logic [1:0]                    rsp_error_code,
   output logic                          rsp_last
);

   dp_cmd_type    dp_cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   imhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .dp_cmd    (dp_cmd)
   );

   imhq_dp #(
      .HEAP_DEPTH (HEAP_DEPTH),
      .ID_BITS    (ID_BITS),
      .COST_BITS  (COST_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .status         (status),
      .csr_we         (csr_valid),
      .csr_data       (csr_data),
      .req_cmd        (req_cmd),
      .req_node_id    (req_node_id),
      .req_f_cost     (req_f_cost),
      .req_h_cost     (req_h_cost),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_is_update  (rsp_is_update),
      .rsp_moved_id   (rsp_moved_id),
      .rsp_slot       (rsp_slot),
      .rsp_head_id    (rsp_head_id),
      .rsp_head_valid (rsp_head_valid),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

endmodule

// File: rtl/imhq_chk.sv
module imhq_chk
   import imhq_pkg::*;
#(
   parameter int ID_BITS = 16
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_is_update,
   input logic [ID_BITS-1:0] rsp_head_id,
   input logic               rsp_head_valid,
   input logic [1:0]         rsp_error_code,
   input logic               rsp_last
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_last))
      else $error("result beat dropped while stalled");

   // drop ready after an accepted beat
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is at work");

   // an error beat stands alone
   a_err_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_NONE |-> rsp_last && !rsp_is_update)
      else $error("error beat is not a lone final beat");

   // an update leaves a nonempty heap
   a_upd_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_update |-> rsp_head_valid && rsp_error_code == ERR_NONE)
      else $error("update beat with empty heap or error");

   // empty heap reports a zero head
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_head_valid |-> rsp_head_id == '0)
      else $error("empty heap shows a head id");

endmodule

bind indexed_min_heap_queue_top imhq_chk #(.ID_BITS(ID_BITS)) u_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_is_update  (rsp_is_update),
   .rsp_head_id    (rsp_head_id),
   .rsp_head_valid (rsp_head_valid),
   .rsp_error_code (rsp_error_code),
   .rsp_last       (rsp_last)
);

// File: tb/indexed_min_heap_queue_top_tb.sv
`timescale 1ns / 1ps

module indexed_min_heap_queue_top_tb;
   import imhq_pkg::*;

   localparam int DEPTH     = 1024;
   localparam int IDLE_WAIT = 20;
   localparam int STALL_MAX = 2000;

   typedef struct {
      logic        cmd;
      logic [15:0] node_id;
      logic [15:0] f_cost;
      logic [15:0] h_cost;
   } heap_op_type;

   typedef struct {
      logic        is_update;
      logic [15:0] moved_id;
      logic [9:0]  slot;
      logic [15:0] head_id;
      logic        head_valid;
      logic [1:0]  error_code;
      logic        last;
   } heap_result_type;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_data;
   logic        req_valid;
   logic        req_ready;
   logic        req_cmd;
   logic [15:0] req_node_id;
   logic [15:0] req_f_cost;
   logic [15:0] req_h_cost;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_is_update;
   logic [15:0] rsp_moved_id;
   logic [9:0]  rsp_slot;
   logic [15:0] rsp_head_id;
   logic        rsp_head_valid;
   logic [1:0]  rsp_error_code;
   logic        rsp_last;

   // shadow heap used for prediction
   logic [15:0]  shadow_id [DEPTH];
   logic [15:0]  shadow_f  [DEPTH];
   logic [15:0]  shadow_h  [DEPTH];
   int           shadow_count;
   logic         shadow_mode;

   heap_op_type     pending_ops[$];
   heap_result_type expected_results[$];
   heap_result_type step_results[$];
   int              mismatch_count;
   int              gen_count;
   int              req_gap;
   int              rsp_stall;
   bit              gap_enable;
   int              quiet_cycles;

   indexed_min_heap_queue_top dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_node_id    (req_node_id),
      .req_f_cost     (req_f_cost),
      .req_h_cost     (req_h_cost),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_is_update  (rsp_is_update),
      .rsp_moved_id   (rsp_moved_id),
      .rsp_slot       (rsp_slot),
      .rsp_head_id    (rsp_head_id),
      .rsp_head_valid (rsp_head_valid),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit ranks_first(int a, int b);
      if (shadow_mode) return shadow_h[a] < shadow_h[b];
      return shadow_f[a] < shadow_f[b] ||
             (shadow_f[a] == shadow_f[b] && shadow_h[a] < shadow_h[b]);
   endfunction

   function automatic void note_move(int s);
      heap_result_type r;
      r = '{1'b1, shadow_id[s], s[9:0], 16'd0, 1'b0, ERR_NONE, 1'b0};
      step_results.push_back(r);
   endfunction

   function automatic void note_plain(logic [1:0] err);
      heap_result_type r;
      r = '{1'b0, 16'd0, 10'd0, 16'd0, 1'b0, err, 1'b0};
      step_results.push_back(r);
   endfunction

   function automatic void swap_entries(int a, int b);
      logic [15:0] t;
      t = shadow_id[a]; shadow_id[a] = shadow_id[b]; shadow_id[b] = t;
      t = shadow_f[a];  shadow_f[a]  = shadow_f[b];  shadow_f[b]  = t;
      t = shadow_h[a];  shadow_h[a]  = shadow_h[b];  shadow_h[b]  = t;
   endfunction

   // compute the result beats of one accepted operation
   function automatic void predict_heap_op(heap_op_type op);
      int c;
      int p;
      int l;
      int rt;
      int best;
      step_results.delete();
      if (op.cmd == CMD_INSERT) begin
         if (shadow_count >= DEPTH) begin
            note_plain(ERR_FULL);
         end else begin
            c = shadow_count;
            shadow_id[c] = op.node_id;
            shadow_f[c]  = op.f_cost;
            shadow_h[c]  = op.h_cost;
            shadow_count++;
            note_move(c);
            while (c > 0) begin
               p = (c - 1) / 2;
               if (!ranks_first(c, p)) break;
               swap_entries(c, p);
               note_move(c);
               note_move(p);
               c = p;
            end
         end
      end else if (shadow_count == 0) begin
         note_plain(ERR_EMPTY);
      end else begin
         shadow_count--;
         if (shadow_count == 0) begin
            note_plain(ERR_NONE);
         end else begin
            shadow_id[0] = shadow_id[shadow_count];
            shadow_f[0]  = shadow_f[shadow_count];
            shadow_h[0]  = shadow_h[shadow_count];
            note_move(0);
            c = 0;
            forever begin
               l = 2 * c + 1;
               rt = 2 * c + 2;
               best = c;
               if (l < shadow_count && ranks_first(l, c)) best = l;
               if (rt < shadow_count && ranks_first(rt, best)) best = rt;
               if (best == c) break;
               swap_entries(c, best);
               note_move(c);
               note_move(best);
               c = best;
            end
         end
      end
      foreach (step_results[k]) begin
         step_results[k].head_valid = shadow_count > 0;
         step_results[k].head_id    = shadow_count > 0 ? shadow_id[0] : 16'd0;
         step_results[k].last       = k == step_results.size() - 1;
         expected_results.push_back(step_results[k]);
      end
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // request driver: hold each beat until accepted, then advance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) predict_heap_op('{req_cmd, req_node_id, req_f_cost, req_h_cost});
         if (req_gap > 0) begin
            req_gap   <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            heap_op_type op;
            op = pending_ops.pop_front();
            req_valid   <= 1'b1;
            req_cmd     <= op.cmd;
            req_node_id <= op.node_id;
            req_f_cost  <= op.f_cost;
            req_h_cost  <= op.h_cost;
            req_gap     <= gap_enable ? $urandom_range(0, 9) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor: check each beat against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_valid && rsp_ready) begin
         int d;
         heap_result_type want;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected beat", 16'd0, 16'd0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_is_update !== want.is_update)
               report_mismatch("is_update", 16'(rsp_is_update), 16'(want.is_update));
            if (rsp_moved_id !== want.moved_id)
               report_mismatch("moved_id", rsp_moved_id, want.moved_id);
            if (rsp_slot !== want.slot)
               report_mismatch("slot", 16'(rsp_slot), 16'(want.slot));
            if (rsp_head_id !== want.head_id)
               report_mismatch("head_id", rsp_head_id, want.head_id);
            if (rsp_head_valid !== want.head_valid)
               report_mismatch("head_valid", 16'(rsp_head_valid), 16'(want.head_valid));
            if (rsp_error_code !== want.error_code)
               report_mismatch("error_code", 16'(rsp_error_code), 16'(want.error_code));
            if (rsp_last !== want.last)
               report_mismatch("last", 16'(rsp_last), 16'(want.last));
         end
         d = gap_enable ? $urandom_range(0, 9) : 0;
         rsp_stall <= d;
         rsp_ready <= d == 0;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ready <= rsp_stall == 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_op(logic cmd, logic [15:0] id, logic [15:0] f, logic [15:0] h);
      heap_op_type op;
      op = '{cmd, id, f, h};
      pending_ops.push_back(op);
      if (cmd == CMD_INSERT && gen_count < DEPTH) gen_count++;
      else if (cmd == CMD_DELETE && gen_count > 0) gen_count--;
   endtask

   // sample between edges so every update of the edge has landed
   task automatic wait_idle();
      while (pending_ops.size() > 0 || req_valid || expected_results.size() > 0)
         @(negedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic write_mode(logic v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      shadow_mode = v;
   endtask

   // random operations: mostly inserts while empty, else inserts at fill_bias percent; ties common
   task automatic random_ops(int n, int fill_bias);
      logic [15:0] f;
      logic [15:0] h;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            f = 16'($urandom());
            h = 16'($urandom());
         end else begin
            f = 16'($urandom_range(0, 7));
            h = 16'($urandom_range(0, 7));
         end
         if (gen_count == 0 && $urandom_range(0, 9) != 0)
            queue_op(CMD_INSERT, 16'($urandom()), f, h);
         else if ($urandom_range(0, 99) < fill_bias)
            queue_op(CMD_INSERT, 16'($urandom()), f, h);
         else
            queue_op(CMD_DELETE, 16'($urandom()), 16'($urandom()), 16'($urandom()));
      end
   endtask

   initial begin
      reset        = 1'b1;
      csr_valid    = 1'b0;
      csr_data     = 1'b0;
      shadow_count = 0;
      shadow_mode  = 1'b0;
      mismatch_count = 0;
      gen_count    = 0;
      gap_enable   = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty delete, extremes, ties, delete of only entry
      write_mode(1'b0);
      queue_op(CMD_DELETE, 16'hffff, 16'hffff, 16'hffff);
      queue_op(CMD_INSERT, 16'hffff, 16'hffff, 16'hffff);
      queue_op(CMD_DELETE, 16'h0000, 16'h0000, 16'h0000);
      queue_op(CMD_INSERT, 16'h0000, 16'h0000, 16'h0000);
      queue_op(CMD_INSERT, 16'hffff, 16'hffff, 16'h0000);
      queue_op(CMD_INSERT, 16'h1234, 16'h0005, 16'h0009);
      queue_op(CMD_INSERT, 16'h5678, 16'h0005, 16'h0003);
      queue_op(CMD_INSERT, 16'h9abc, 16'h0000, 16'hffff);
      queue_op(CMD_INSERT, 16'haaaa, 16'h0005, 16'h0003);
      queue_op(CMD_INSERT, 16'h5555, 16'h8000, 16'h0001);
      for (int i = 0; i < 9; i++) queue_op(CMD_DELETE, 16'h0, 16'h0, 16'h0);
      wait_idle();

      // cost-limited ordering with stalls
      write_mode(1'b1);
      queue_op(CMD_INSERT, 16'h0001, 16'h0000, 16'h0010);
      queue_op(CMD_INSERT, 16'h0002, 16'hffff, 16'h0001);
      queue_op(CMD_INSERT, 16'h0003, 16'h0001, 16'h0001);
      random_ops(90, 60);
      wait_idle();

      // back-to-back stretch without idling, then a stretch with gaps again
      write_mode(1'b0);
      gap_enable = 1'b0;
      random_ops(50, 55);
      wait_idle();
      gap_enable = 1'b1;
      random_ops(50, 45);
      wait_idle();

      // drain toward empty in cost-limited mode
      write_mode(1'b1);
      random_ops(30, 20);
      wait_idle();

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
